// ===== rtl/assert_macros.svh =====
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/brcd_pkg.sv =====
`default_nettype none

package brcd_pkg;

    localparam int MAX_ROWS_DEF     = 64;
    localparam int MAX_COLUMNS_DEF  = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 7'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Result tag that travels alongside the RAM read.
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } result_meta_t;

endpackage

`default_nettype wire

// ===== rtl/brcd_ram.sv =====
`default_nettype none

module brcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/brcd_ctrl.sv =====
`default_nettype none

module brcd_ctrl #(
    parameter int MAX_ROWS     = brcd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS  = brcd_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_WIDTH = brcd_pkg::SAMPLE_WIDTH_DEF,
    parameter int ADDR_W       = 13
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_accept,
    input  wire logic                                kind,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    input  wire logic                                cfg_write,
    input  wire logic [brcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [brcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     wr_en,
    output logic [ADDR_W-1:0]                        wr_addr,
    output logic [SAMPLE_WIDTH-1:0]                  wr_data,
    output logic                                     rd_en,
    output logic [ADDR_W-1:0]                        rd_addr,
    output brcd_pkg::result_meta_t                   meta
);

    import brcd_pkg::*;

    `include "assert_macros.svh"

    localparam int OFS_W  = ADDR_W - 1;
    localparam int TOT_W  = OFS_W + 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);

    logic [CFG_DATA_W-1:0] row_count_reg;
    logic [CFG_DATA_W-1:0] column_count_reg;

    logic [OFS_W-1:0] fill_pos_reg,      fill_pos_next;
    logic             fill_sel_reg,      fill_sel_next;
    logic             fill_complete_reg, fill_complete_next;
    logic             drain_ready_reg,   drain_ready_next;
    logic [ROW_W-1:0] drain_row_reg,     drain_row_next;
    logic [COL_W-1:0] drain_col_reg,     drain_col_next;

    logic [RCNT_W-1:0] rows;
    logic [CCNT_W-1:0] cols;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  fill_inc;
    logic [TOT_W-1:0]  rd_ofs;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic              is_sample;
    logic              refuse;
    logic              do_read;
    logic              do_write;
    logic              fill_done;
    logic              row_last;
    logic              col_last;
    logic              block_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_RESET;
            column_count_reg <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else if (cfg_index == CFG_COLUMN_COUNT)
            begin
                column_count_reg <= cfg_data;
            end
        end
    end

    // Clamp counts: zero reads as one, large values saturate.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows = RCNT_W'(1);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            rows = RCNT_W'(MAX_ROWS);
        end
        else
        begin
            rows = RCNT_W'(row_count_reg);
        end

        if (column_count_reg == '0)
        begin
            cols = CCNT_W'(1);
        end
        else if (32'(column_count_reg) > MAX_COLUMNS)
        begin
            cols = CCNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = CCNT_W'(column_count_reg);
        end
    end

    assign total  = TOT_W'(rows) * TOT_W'(cols);
    assign rd_ofs = TOT_W'(drain_col_reg) * TOT_W'(rows) + TOT_W'(drain_row_reg);

    assign is_sample = (kind == KIND_SAMPLE);
    assign refuse    = is_sample && fill_complete_reg && drain_ready_reg;
    assign do_read   = drain_ready_reg && !refuse;
    assign do_write  = is_sample && !fill_complete_reg;

    assign fill_inc  = {1'b0, fill_pos_reg} + TOT_W'(1);
    assign fill_done = (fill_inc >= total);
    assign row_inc   = {1'b0, drain_row_reg} + (ROW_W + 1)'(1);
    assign col_inc   = {1'b0, drain_col_reg} + (COL_W + 1)'(1);
    assign row_last  = (32'(row_inc) >= 32'(rows));
    assign col_last  = (32'(col_inc) >= 32'(cols));
    assign block_last = col_last && row_last;

    always_comb
    begin
        fill_pos_next      = fill_pos_reg;
        fill_sel_next      = fill_sel_reg;
        fill_complete_next = fill_complete_reg;
        drain_ready_next   = drain_ready_reg;
        drain_row_next     = drain_row_reg;
        drain_col_next     = drain_col_reg;

        if (item_accept)
        begin
            // Advance the transposed read position.
            if (do_read)
            begin
                if (col_last)
                begin
                    drain_col_next = '0;
                    if (row_last)
                    begin
                        drain_row_next   = '0;
                        drain_ready_next = 1'b0;
                    end
                    else
                    begin
                        drain_row_next = row_inc[ROW_W-1:0];
                    end
                end
                else
                begin
                    drain_col_next = col_inc[COL_W-1:0];
                end
            end

            if (do_write)
            begin
                if (fill_done)
                begin
                    fill_pos_next      = '0;
                    fill_complete_next = 1'b1;
                end
                else
                begin
                    fill_pos_next = fill_inc[OFS_W-1:0];
                end
            end

            // Hand a full bank to the drain side once it is free.
            if (fill_complete_next && !drain_ready_next)
            begin
                fill_sel_next      = !fill_sel_reg;
                fill_complete_next = 1'b0;
                drain_ready_next   = 1'b1;
                drain_row_next     = '0;
                drain_col_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pos_reg      <= '0;
            fill_sel_reg      <= 1'b0;
            fill_complete_reg <= 1'b0;
            drain_ready_reg   <= 1'b0;
            drain_row_reg     <= '0;
            drain_col_reg     <= '0;
        end
        else
        begin
            fill_pos_reg      <= fill_pos_next;
            fill_sel_reg      <= fill_sel_next;
            fill_complete_reg <= fill_complete_next;
            drain_ready_reg   <= drain_ready_next;
            drain_row_reg     <= drain_row_next;
            drain_col_reg     <= drain_col_next;
        end
    end

    assign wr_en   = item_accept && do_write;
    assign wr_addr = {fill_sel_reg, fill_pos_reg};
    assign wr_data = sample_in;
    assign rd_en   = item_accept && do_read;
    assign rd_addr = {!fill_sel_reg, rd_ofs[OFS_W-1:0]};

    assign meta.valid = item_accept && (refuse || do_read);
    assign meta.last  = do_read && block_last;
    assign meta.ovf   = refuse;

    `ASSERT_IMPLY(a_complete_has_drain, fill_complete_reg, drain_ready_reg)
    `ASSERT_NEXT(a_refuse_holds_fill, item_accept && refuse, $stable(fill_pos_reg) && $stable(fill_sel_reg))
    `ASSERT_NEXT(a_handover_restarts, item_accept && !drain_ready_reg && drain_ready_next, drain_row_reg == '0 && drain_col_reg == '0)

endmodule

`default_nettype wire

// ===== rtl/brcd_out_stage.sv =====
`default_nettype none

module brcd_out_stage #(
    parameter int SAMPLE_WIDTH = brcd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_accept,
    input  wire brcd_pkg::result_meta_t          meta,
    input  wire logic [SAMPLE_WIDTH-1:0]         rd_data,
    input  wire logic                            result_stall,
    output logic                                 item_stall,
    output logic                                 result_valid,
    output logic signed [SAMPLE_WIDTH-1:0]       sample_out,
    output logic                                 end_of_block,
    output logic                                 overflow
);

    import brcd_pkg::*;

    `include "assert_macros.svh"

    result_meta_t             s1_reg, s1_next;
    logic                     result_valid_reg, result_valid_next;
    logic [SAMPLE_WIDTH-1:0]  sample_out_reg;
    logic                     end_of_block_reg;
    logic                     overflow_reg;
    logic                     s1_adv;

    // s1 lines up with the registered RAM read; it moves on when the result
    // register is empty or being taken.
    assign s1_adv     = s1_reg.valid && (!result_valid_reg || !result_stall);
    assign item_stall = s1_reg.valid && result_valid_reg && result_stall;

    always_comb
    begin
        s1_next = s1_reg;
        if (item_accept)
        begin
            s1_next = meta;
        end
        else if (s1_adv)
        begin
            s1_next = '0;
        end

        result_valid_next = result_valid_reg;
        if (s1_adv)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg           <= s1_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            sample_out_reg   <= s1_reg.ovf ? '0 : rd_data;
            end_of_block_reg <= s1_reg.last;
            overflow_reg     <= s1_reg.ovf;
        end
    end

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign end_of_block = end_of_block_reg;
    assign overflow     = overflow_reg;

    `ASSERT_IMPLY(a_ovf_not_last, result_valid_reg, !(end_of_block_reg && overflow_reg))
    `ASSERT_NEXT(a_s1_kept, s1_reg.valid && !s1_adv, s1_reg.valid)

endmodule

`default_nettype wire

// ===== rtl/block_row_column_deinterleaver.sv =====
// Row/column block deinterleaver with two ping-pong banks in one RAM of
// 2 ** ADDR_W words. Samples fill a rows-by-columns block in arrival order
// and drain transposed; each accepted transaction (sample or drain tick)
// emits one result while a full bank is draining, and a sample that
// arrives while both banks are full comes back as an overflow result with
// a zero sample. The block takes one transaction per clock cycle while
// item_stall is low: each one needs at most a single RAM write and a
// single RAM read, both issued at the edge that accepts it. The result moves
// into the output register once that register is empty or being taken;
// while the output is stalled one more result can wait behind it before
// the input stalls. The bank RAM is not cleared after reset and the block
// is ready at once. Write row_count and column_count only between blocks;
// a mid-block change ends the block at the first position at or past the
// new size.
`default_nettype none

module block_row_column_deinterleaver #(
    parameter int MAX_ROWS     = brcd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS  = brcd_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_WIDTH = brcd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic                              kind,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
    output logic                                   end_of_block,
    output logic                                   overflow,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [brcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [brcd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import brcd_pkg::*;

    localparam int BANK_SIZE = MAX_ROWS * MAX_COLUMNS;
    localparam int OFS_W     = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam int ADDR_W    = OFS_W + 1;

    logic                    item_accept;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    result_meta_t            meta;

    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    brcd_ctrl #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_accept  (item_accept),
        .kind         (kind),
        .sample_in    (sample_in),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .meta         (meta)
    );

    brcd_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (2 ** ADDR_W)
    ) u_bank_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    brcd_out_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_accept  (item_accept),
        .meta         (meta),
        .rd_data      (rd_data),
        .result_stall (result_stall),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .sample_out   (sample_out),
        .end_of_block (end_of_block),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire
